FILE: rtl/core/bitmap_block_allocator_core_macros.svh
// assertion macros used by the allocator checker
// each one samples on clk and is held off while rst_n is low
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba check failed: same-cycle rule");

// consequent checked in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba check failed: next-cycle rule");

`endif

FILE: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int IDX_W         = 12;
    localparam int MAP_BYTES_DEF = 512;
    localparam int INDEX_BYTES   = 512;
    localparam int BYTE_W        = 8;
    localparam int ROW_BYTES     = 8;
    localparam int ROW_BITS      = ROW_BYTES * BYTE_W;
    localparam int BIT_SEL_W     = $clog2(BYTE_W);
    localparam int BYTE_SEL_W    = $clog2(ROW_BYTES);
    localparam int ROW_POS_W     = BYTE_SEL_W + BIT_SEL_W;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    localparam logic REQ_MARK = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    localparam logic SEL_INODE = 1'b0;
    localparam logic SEL_DATA  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_FIND,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             req_type;
        logic             bitmap_sel;
        logic [IDX_W-1:0] bit_index;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] free_index;
    } rsp_t;

    typedef struct packed {
        logic                 found;
        logic [ROW_POS_W-1:0] pos;
    } ffz_res_t;

endpackage

FILE: rtl/core/bba_row_ram.sv
`timescale 1ns / 1ps

// one bitmap, one row of bytes per entry, registered read
module bba_row_ram #(
    parameter int DEPTH = bba_pkg::MAP_BYTES_DEF / bba_pkg::ROW_BYTES,
    parameter int AW    = $clog2(bba_pkg::MAP_BYTES_DEF / bba_pkg::ROW_BYTES),
    parameter int W     = bba_pkg::ROW_BITS
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/bba_ffz.sv
`timescale 1ns / 1ps

// lowest clear bit of one row, bytes past the search limit read as full
module bba_ffz #(
    parameter int LAST_BYTES = bba_pkg::ROW_BYTES
) (
    input  logic [bba_pkg::ROW_BITS-1:0] row_data,
    input  logic                         last_row,
    output bba_pkg::ffz_res_t            res
);

    logic [bba_pkg::ROW_BYTES-1:0] byte_free;
    logic [bba_pkg::BIT_SEL_W-1:0] byte_pos [bba_pkg::ROW_BYTES];

    always_comb
    begin : byte_scan
        logic [bba_pkg::BYTE_W-1:0] cur_byte;
        for (int j = 0; j < bba_pkg::ROW_BYTES; j++)
        begin
            cur_byte = row_data[j*bba_pkg::BYTE_W +: bba_pkg::BYTE_W];
            if (last_row && (j >= LAST_BYTES))
            begin
                cur_byte = bba_pkg::FULL_BYTE;
            end
            byte_free[j] = (cur_byte != bba_pkg::FULL_BYTE);
            byte_pos[j]  = '0;
            for (int k = bba_pkg::BYTE_W - 1; k >= 0; k--)
            begin
                if (!cur_byte[k])
                begin
                    byte_pos[j] = bba_pkg::BIT_SEL_W'(k);
                end
            end
        end
    end

    always_comb
    begin
        res.found = |byte_free;
        res.pos   = '0;
        for (int j = bba_pkg::ROW_BYTES - 1; j >= 0; j--)
        begin
            if (byte_free[j])
            begin
                res.pos = {bba_pkg::BYTE_SEL_W'(j), byte_pos[j]};
            end
        end
    end

endmodule

FILE: rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps

// sequencer: clear pass, mark read-modify-write, row-by-row search, result register
module bba_ctrl #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF,
    parameter int ROWS      = bba_pkg::MAP_BYTES_DEF / bba_pkg::ROW_BYTES,
    parameter int ROW_AW    = $clog2(bba_pkg::MAP_BYTES_DEF / bba_pkg::ROW_BYTES),
    parameter int SCAN_ROWS = bba_pkg::INDEX_BYTES / bba_pkg::ROW_BYTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bba_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bba_pkg::rsp_t                rsp,
    output logic [ROW_AW-1:0]            rd_addr,
    output logic [ROW_AW-1:0]            wr_addr,
    output logic [bba_pkg::ROW_BITS-1:0] wr_data,
    output logic                         wr_inode,
    output logic                         wr_dmap,
    input  logic [bba_pkg::ROW_BITS-1:0] inode_rd,
    input  logic [bba_pkg::ROW_BITS-1:0] dmap_rd,
    input  bba_pkg::ffz_res_t            ffz_res,
    output logic                         scan_last
);

    localparam int LIMIT_W = bba_pkg::IDX_W + 1;
    localparam logic [ROW_AW-1:0]  LAST_ROW  = ROW_AW'(ROWS - 1);
    localparam logic [ROW_AW-1:0]  LAST_SCAN = ROW_AW'(SCAN_ROWS - 1);
    localparam logic [LIMIT_W-1:0] MAP_LIMIT = LIMIT_W'(MAP_BYTES);

    bba_pkg::state_t                 state_reg, state_next;
    logic [ROW_AW-1:0]               row_reg, row_next;
    logic                            sel_reg, sel_next;
    logic                            hit_reg, hit_next;
    logic [bba_pkg::ROW_POS_W-1:0]   pos_reg, pos_next;
    bba_pkg::rsp_t                   res_reg, res_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    bba_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            in_range;
    logic [ROW_AW-1:0]               mark_row;
    logic                            out_free;
    logic                            is_last_row;

    assign in_range    = (LIMIT_W'(req.bit_index[bba_pkg::IDX_W-1:bba_pkg::BIT_SEL_W])
                          < MAP_LIMIT);
    assign mark_row    = in_range
                       ? ROW_AW'(req.bit_index[bba_pkg::IDX_W-1:bba_pkg::ROW_POS_W])
                       : '0;
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign is_last_row = (row_reg == LAST_ROW);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                if (is_last_row)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.req_type == bba_pkg::REQ_FIND)
                               ? bba_pkg::ST_FIND : bba_pkg::ST_MARK;
                end
            end
            bba_pkg::ST_MARK:
            begin
                state_next = bba_pkg::ST_RESP;
            end
            bba_pkg::ST_FIND:
            begin
                if (ffz_res.found || (row_reg == LAST_SCAN))
                begin
                    state_next = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_ready      = 1'b0;
        rd_addr        = '0;
        wr_addr        = row_reg;
        wr_data        = '0;
        wr_inode       = 1'b0;
        wr_dmap        = 1'b0;
        scan_last      = 1'b0;
        row_next       = row_reg;
        sel_next       = sel_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                wr_inode = 1'b1;
                wr_dmap  = 1'b1;
                row_next = is_last_row ? '0 : row_reg + ROW_AW'(1);
            end
            bba_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_addr   = (req.req_type == bba_pkg::REQ_FIND) ? '0 : mark_row;
                if (req_valid)
                begin
                    sel_next = req.bitmap_sel;
                    hit_next = in_range;
                    pos_next = req.bit_index[bba_pkg::ROW_POS_W-1:0];
                    row_next = (req.req_type == bba_pkg::REQ_FIND) ? '0 : mark_row;
                end
            end
            bba_pkg::ST_MARK:
            begin
                wr_data  = ((sel_reg == bba_pkg::SEL_DATA) ? dmap_rd : inode_rd)
                         | (bba_pkg::ROW_BITS'(1) << pos_reg);
                wr_inode = hit_reg && (sel_reg == bba_pkg::SEL_INODE);
                wr_dmap  = hit_reg && (sel_reg == bba_pkg::SEL_DATA);
                res_next = '{status: bba_pkg::STATUS_OK, free_index: '0};
            end
            bba_pkg::ST_FIND:
            begin
                scan_last = (row_reg == LAST_SCAN);
                rd_addr   = scan_last ? row_reg : row_reg + ROW_AW'(1);
                if (ffz_res.found)
                begin
                    res_next = '{status: bba_pkg::STATUS_OK,
                                 free_index: bba_pkg::IDX_W'({row_reg, ffz_res.pos})};
                end
                else if (scan_last)
                begin
                    res_next = '{status: bba_pkg::STATUS_FULL, free_index: '0};
                end
                else
                begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end
            bba_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_CLEAR;
            row_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        hit_reg <= hit_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/core/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps

// bitmap block allocator: two allocation bitmaps (inodes, data blocks) of MAP_BYTES bytes,
// bit k of byte b standing for index b*8+k. a mark beat sets one bit in the selected map
// (out-of-range marks change nothing) and answers status 0 / index 0. a find beat returns
// the lowest clear inode bit as a full 12-bit index, or status 1 when the searchable part
// (the first min(MAP_BYTES, 512) bytes) is full. each map is a single-port-write ram of
// 64-bit rows with a registered read; a single find-first-zero unit on the inode ram checks
// one row per cycle. after reset a clearing pass writes ceil(MAP_BYTES/8) rows (64 at the
// default size) with req_ready low. a mark passes read, write back and result before the
// next accept. a find scans rows from row 0 up to the first row with a clear bit, at most
// ceil(min(MAP_BYTES,512)/8) rows, before its result. the result sits in an output
// register, so a new request is taken while it waits.
module bitmap_block_allocator_core #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bba_pkg::rsp_t rsp
);

    // row geometry
    localparam int ROWS       = (MAP_BYTES + bba_pkg::ROW_BYTES - 1) / bba_pkg::ROW_BYTES;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    // search covers only bytes whose indices fit in 12 bits
    localparam int SCAN_BYTES = (MAP_BYTES < bba_pkg::INDEX_BYTES)
                              ? MAP_BYTES : bba_pkg::INDEX_BYTES;
    localparam int SCAN_ROWS  = (SCAN_BYTES + bba_pkg::ROW_BYTES - 1) / bba_pkg::ROW_BYTES;
    // live bytes in the last searched row
    localparam int LAST_BYTES = SCAN_BYTES - bba_pkg::ROW_BYTES * (SCAN_ROWS - 1);

    logic [ROW_AW-1:0]            rd_addr;
    logic [ROW_AW-1:0]            wr_addr;
    logic [bba_pkg::ROW_BITS-1:0] wr_data;
    logic                         wr_inode;
    logic                         wr_dmap;
    logic [bba_pkg::ROW_BITS-1:0] inode_rd;
    logic [bba_pkg::ROW_BITS-1:0] dmap_rd;
    bba_pkg::ffz_res_t            ffz_res;
    logic                         scan_last;

    // sequencer and result register
    bba_ctrl #(
        .MAP_BYTES (MAP_BYTES),
        .ROWS      (ROWS),
        .ROW_AW    (ROW_AW),
        .SCAN_ROWS (SCAN_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .wr_inode  (wr_inode),
        .wr_dmap   (wr_dmap),
        .inode_rd  (inode_rd),
        .dmap_rd   (dmap_rd),
        .ffz_res   (ffz_res),
        .scan_last (scan_last)
    );

    // inode bitmap
    bba_row_ram #(
        .DEPTH (ROWS),
        .AW    (ROW_AW),
        .W     (bba_pkg::ROW_BITS)
    ) u_inode_ram (
        .clk     (clk),
        .we      (wr_inode),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (inode_rd)
    );

    // data block bitmap
    bba_row_ram #(
        .DEPTH (ROWS),
        .AW    (ROW_AW),
        .W     (bba_pkg::ROW_BITS)
    ) u_dmap_ram (
        .clk     (clk),
        .we      (wr_dmap),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (dmap_rd)
    );

    // find-first-zero unit on the inode row just read
    bba_ffz #(
        .LAST_BYTES (LAST_BYTES)
    ) u_ffz (
        .row_data (inode_rd),
        .last_row (scan_last),
        .res      (ffz_res)
    );

endmodule

FILE: rtl/core/bba_checker.sv
`timescale 1ns / 1ps

`include "bitmap_block_allocator_core_macros.svh"

module bba_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bba_pkg::rsp_t rsp
);

    // a stalled result beat holds
    `BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // a full map never reports an index
    `BBA_ASSERT_SAME(a_full_no_index, rsp_valid && (rsp.status == bba_pkg::STATUS_FULL), rsp.free_index == '0)

    // one request at a time: busy right after an accept
    `BBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
